@@ rtl/a64dp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_pkg: shared types and constants
// Decoded operation record passed from the front end to the execute back end.
// ----------------------------------------------------------------------------
package a64dp_pkg;

  localparam int unsigned IW_W = 32;
  localparam int unsigned XLEN = 64;
  localparam logic [4:0] ZR_IDX = 5'd31;
  localparam logic [15:0] HALF_MASK = 16'hffff;

  typedef enum logic [2:0] {
    OPK_ADDSUB = 3'd0,
    OPK_MOVW   = 3'd1,
    OPK_LOGIC  = 3'd2,
    OPK_MUL    = 3'd3,
    OPK_BAD    = 3'd4
  } op_kind_t;

  // Decoded instruction.
  typedef struct packed {
    op_kind_t    kind;
    logic        sf;
    logic [1:0]  opc;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic [4:0]  ra;
    logic        b_imm;      // second operand is an immediate
    logic [63:0] imm;
    logic [1:0]  sh_type;
    logic [5:0]  sh_amt;
    logic        negb;       // invert second operand (logic group)
    logic        msub;
    logic [1:0]  hw;
  } dec_op_t;

endpackage

@@ rtl/a64dp_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_decode: instruction classifier
// Pure combinational decode of one instruction into a dec_op_t record.
// ----------------------------------------------------------------------------
module a64dp_decode import a64dp_pkg::*; (
  input  logic          action,
  input  logic [31:0]   iw,
  output dec_op_t       dec
);

  always_comb begin
    dec = '0;
    dec.kind    = OPK_BAD;
    dec.sf      = iw[31];
    dec.opc     = iw[30:29];
    dec.rd      = iw[4:0];
    dec.rn      = iw[9:5];
    dec.rm      = iw[20:16];
    dec.ra      = iw[14:10];
    dec.sh_type = iw[23:22];
    dec.sh_amt  = iw[15:10];
    dec.negb    = iw[21];
    dec.msub    = iw[15];
    dec.hw      = iw[22:21];
    if (!action) begin
      dec.b_imm = 1'b1;
      if (iw[25:23] == 3'b010) begin
        dec.kind = OPK_ADDSUB;
        dec.imm  = iw[22] ? {40'd0, iw[21:10], 12'd0} : {52'd0, iw[21:10]};
      end else if (iw[25:23] == 3'b101) begin
        dec.imm = {48'd0, iw[20:5]};
        if (!(iw[30:29] == 2'b01 || (!iw[31] && iw[22])))
          dec.kind = OPK_MOVW;
      end
    end else if (!iw[28]) begin
      if (!(!iw[31] && iw[15])) begin
        if (iw[24])
          dec.kind = iw[21] ? OPK_BAD : OPK_ADDSUB;
        else
          dec.kind = OPK_LOGIC;
      end
    end else if (iw[24:21] == 4'b1000) begin
      dec.kind = OPK_MUL;
    end
  end

endmodule

@@ rtl/a64dp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_fifo: decoded-op queue
// Two-entry queue that decouples the decode front from the execute back.
// ----------------------------------------------------------------------------
module a64dp_fifo import a64dp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dec_op_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output dec_op_t out_data
);

  dec_op_t     mem [2];
  logic        wp;
  logic        rp;
  logic [1:0]  count;

  logic push, pop;
  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/a64dp_execute.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64dp_execute: execute back end
// Reads the register file, computes the result and flags, writes back and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module a64dp_execute import a64dp_pkg::*; #(
  parameter int REG_COUNT = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  dec_op_t     op,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        res_we,
  output logic [4:0]  res_rd,
  output logic [63:0] res_value,
  output logic [3:0]  res_nzcv,
  output logic        res_invalid
);

  logic [63:0] regs [REG_COUNT];
  logic [3:0]  nzcv;

  logic [63:0] mask, a, b, bs, acc, r, prod, sum, old;
  logic [63:0] p_ll;
  logic [31:0] p_lh, p_hl;
  logic [64:0] add_full;
  logic [3:0]  nzcv_next;
  logic [5:0]  amt, inv_amt;
  logic        top_r, top_a, top_b, valid_op, fire;
  logic [127:0] rot;

  function automatic logic [63:0] rd_reg(input logic [4:0] idx, input logic [63:0] msk);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < REG_COUNT; i++)
      if (idx == i[4:0]) v = regs[i];
    return v & msk;
  endfunction

  assign op_ready = !res_valid || res_ready;
  assign fire = op_valid && op_ready;

  always_comb begin
    mask = op.sf ? '1 : 64'h0000_0000_ffff_ffff;
    a    = rd_reg(op.rn, mask);
    bs   = rd_reg(op.rm, mask);
    acc  = rd_reg(op.ra, mask);
    old  = rd_reg(op.rd, '1);
    amt  = op.sh_amt;
    inv_amt = op.sf ? 6'd0 - amt : 6'd32 - amt;
    rot = '0;
    case (op.sh_type)
      2'd0: b = (bs << amt) & mask;
      2'd1: b = bs >> amt;
      2'd2: begin
        b = bs >> amt;
        if ((op.sf ? bs[63] : bs[31]) && amt != 6'd0) b = b | (mask & ~(mask >> amt));
      end
      default: begin
        rot = {bs, bs} >> amt;
        if (amt == 6'd0) b = bs;
        else if (op.sf) b = rot[63:0];
        else b = ((bs >> amt) | (bs << inv_amt[4:0])) & mask;
      end
    endcase
    if (op.b_imm) b = op.imm & mask;
    // low 64 bits of the product from 32x32 partial products
    p_ll = a[31:0] * bs[31:0];
    p_lh = a[31:0] * bs[63:32];
    p_hl = a[63:32] * bs[31:0];
    prod = p_ll + {p_lh + p_hl, 32'd0};
    nzcv_next = nzcv;
    valid_op = 1'b1;
    r = '0;
    add_full = '0;
    sum = '0;
    top_r = 1'b0;
    top_a = 1'b0;
    top_b = 1'b0;
    case (op.kind)
      OPK_ADDSUB: begin
        add_full = op.opc[1] ? {1'b0, a} + {1'b0, ~b & mask} + 65'd1
                             : {1'b0, a} + {1'b0, b};
        sum = add_full[63:0] & mask;
        r = sum;
        top_r = op.sf ? sum[63] : sum[31];
        top_a = op.sf ? a[63] : a[31];
        top_b = op.sf ? b[63] : b[31];
        if (op.opc[0]) begin
          nzcv_next[3] = top_r;
          nzcv_next[2] = (sum == 64'd0);
          nzcv_next[1] = op.opc[1] ? (a >= b) : (op.sf ? add_full[64] : add_full[32]);
          nzcv_next[0] = op.opc[1] ? ((top_a ^ top_b) & (top_a ^ top_r))
                                   : ((top_a ^ top_r) & (top_b ^ top_r));
        end
      end
      OPK_MOVW: begin
        case (op.opc)
          2'd0: r = ~(op.imm << {op.hw, 4'd0}) & mask;
          2'd2: r = (op.imm << {op.hw, 4'd0}) & mask;
          default: r = ((old & ~({48'd0, HALF_MASK} << {op.hw, 4'd0}))
                        | (op.imm << {op.hw, 4'd0})) & mask;
        endcase
      end
      OPK_LOGIC: begin
        sum = op.negb ? ~b & mask : b;
        case (op.opc)
          2'd1: r = a | sum;
          2'd2: r = a ^ sum;
          default: r = a & sum;
        endcase
        r = r & mask;
        if (op.opc == 2'd3) nzcv_next = {op.sf ? r[63] : r[31], r == 64'd0, 2'b00};
      end
      OPK_MUL: r = (op.msub ? acc - prod : acc + prod) & mask;
      default: valid_op = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      nzcv <= 4'd0;
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= '0;
    end else begin
      if (fire) begin
        res_rd      <= op.rd;
        res_value   <= r;
        res_we      <= valid_op && op.rd != ZR_IDX;
        res_invalid <= !valid_op;
        res_nzcv    <= nzcv_next;
        for (int i = 0; i < REG_COUNT; i++)
          if (valid_op && op.rd == i[4:0]) regs[i] <= r;
        res_valid <= 1'b1;
        nzcv <= nzcv_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/a64_data_processing_execute.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64_data_processing_execute: A64 data-processing execute unit
// Decodes and executes integer ALU, wide-move and multiply-add instructions.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one instruction beat: tuser = class (0 immediate,
//   1 register), tdata = 32-bit instruction word.
//   m_axis returns one result beat per instruction: tdata packs
//   write_enable, dest_index, write_value, flags_nzcv, invalid.
//   The front end decodes into a two-entry queue; the back end reads the
//   register file, executes and writes back at the same edge
//   the result register loads, so a dependent instruction in the next
//   cycle sees the new value.
//   The single execute stage follows the queue and loads the result register.
//   Throughput: one instruction per cycle while m_axis_tready is high.
//   Reset clears the registers, flags and queue; no beat is pending after.
//   When m_axis stalls, the result register holds, the queue fills, and
//   s_axis_tready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module a64_data_processing_execute import a64dp_pkg::*; #(
  parameter int REG_COUNT = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // instruction_word
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // write_enable, dest_index[5],
                                      // write_value[64], flags_nzcv[4], invalid
);

  dec_op_t dec, q_op;
  logic    q_valid, q_ready;
  logic        we, inv;
  logic [4:0]  rd;
  logic [63:0] val;
  logic [3:0]  f;

  a64dp_decode u_dec (.action(s_axis_tuser), .iw(s_axis_tdata), .dec(dec));

  a64dp_fifo u_q (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(dec),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_op)
  );

  a64dp_execute #(.REG_COUNT(REG_COUNT)) u_ex (
    .clk(clk), .rst(rst),
    .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_we(we), .res_rd(rd), .res_value(val), .res_nzcv(f), .res_invalid(inv)
  );

  assign m_axis_tdata = {5'd0, inv, f, val, rd, we};

endmodule

@@ dv/a64_data_processing_execute_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64_data_processing_execute_checker: result predictor and scoreboard
// Watches the instruction and result streams, runs its own register file
// and flags to predict every result beat, and counts mismatches.
// ----------------------------------------------------------------------------
module a64_data_processing_execute_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // instruction_word
  input  logic        s_axis_tuser,   // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,   // write_enable, dest_index[5],
                                      // write_value[64], flags_nzcv[4], invalid
  output int          errors,
  output int          pending
);

  localparam logic ACT_IMM = 1'b0;
  localparam int   NREGS   = 31;

  // most significant field first, so wen lands in bit 0
  typedef struct packed {
    logic        bad;
    logic [3:0]  nzcv;
    logic [63:0] val;
    logic [4:0]  rd;
    logic        wen;
  } exec_result_t;

  logic [63:0]  gpr [NREGS];
  logic [3:0]   nzcv_q;
  exec_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [63:0] wmask(logic sf);
    return sf ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
  endfunction

  function automatic logic [63:0] rd_gpr(logic [4:0] idx, logic sf);
    if (idx >= NREGS) return 64'd0;
    return gpr[idx] & wmask(sf);
  endfunction

  // opc[1] subtract, opc[0] set flags
  function automatic logic [63:0] add_sub(logic [63:0] a, logic [63:0] b, logic sf,
                                          logic [1:0] opc, ref logic [3:0] fl);
    logic [63:0] m, r;
    logic [64:0] s;
    int top;
    logic n, z, c, v;
    m = wmask(sf);
    top = sf ? 63 : 31;
    a &= m;
    b &= m;
    s = opc[1] ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, b};
    r = s[63:0] & m;
    if (opc[0]) begin
      n = r[top];
      z = (r == 0);
      if (opc[1]) begin
        c = (a >= b);
        v = (a[top] ^ b[top]) & (a[top] ^ r[top]);
      end else begin
        c = sf ? s[64] : s[32];
        v = (a[top] ^ r[top]) & (b[top] ^ r[top]);
      end
      fl = {n, z, c, v};
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_operand(logic [63:0] x, logic [1:0] ty,
                                                int amt, logic sf);
    logic [63:0] m, r;
    int w;
    m = wmask(sf);
    w = sf ? 64 : 32;
    x &= m;
    case (ty)
      2'd0: return (x << amt) & m;
      2'd1: return x >> amt;
      2'd2: begin
        r = x >> amt;
        if (x[w-1] && amt != 0) r |= m & ~(m >> amt);
        return r;
      end
      default: begin
        if (amt == 0) return x;
        return ((x >> amt) | (x << (w - amt))) & m;
      end
    endcase
  endfunction

  function automatic exec_result_t execute(logic act, logic [31:0] iw);
    exec_result_t o;
    logic sf, ok;
    logic [1:0] opc;
    logic [63:0] m, res, a, b, imm, acc, p;
    logic [3:0] fl;
    int amt, sh;
    sf = iw[31];
    opc = iw[30:29];
    m = wmask(sf);
    fl = nzcv_q;
    res = 0;
    ok = 1'b0;
    if (act == ACT_IMM) begin
      if (iw[25:23] == 3'b010) begin
        imm = {52'd0, iw[21:10]};
        if (iw[22]) imm <<= 12;
        res = add_sub(rd_gpr(iw[9:5], sf), imm, sf, opc, fl);
        ok = 1'b1;
      end else if (iw[25:23] == 3'b101) begin
        sh = iw[22:21] * 16;
        imm = {48'd0, iw[20:5]};
        if (!(opc == 2'd1 || (!sf && iw[22]))) begin
          ok = 1'b1;
          if (opc == 2'd0) res = ~(imm << sh) & m;
          else if (opc == 2'd2) res = (imm << sh) & m;
          else res = ((rd_gpr(iw[4:0], 1'b1) & ~(64'hffff << sh)) | (imm << sh)) & m;
        end
      end
    end else if (!iw[28]) begin
      amt = iw[15:10];
      if (!(!sf && amt >= 32)) begin
        b = shift_operand(rd_gpr(iw[20:16], sf), iw[23:22], amt, sf);
        a = rd_gpr(iw[9:5], sf);
        if (iw[24]) begin
          if (!iw[21]) begin
            res = add_sub(a, b, sf, opc, fl);
            ok = 1'b1;
          end
        end else begin
          if (iw[21]) b = ~b & m;
          if (opc == 2'd1) res = a | b;
          else if (opc == 2'd2) res = a ^ b;
          else res = a & b;
          res &= m;
          if (opc == 2'd3) fl = {res[sf ? 63 : 31], res == 0, 2'b00};
          ok = 1'b1;
        end
      end
    end else if (iw[24:21] == 4'b1000) begin
      acc = rd_gpr(iw[14:10], sf);
      p = rd_gpr(iw[9:5], sf) * rd_gpr(iw[20:16], sf);
      res = (iw[15] ? acc - p : acc + p) & m;
      ok = 1'b1;
    end
    if (!ok) begin
      res = 0;
      fl = nzcv_q;
    end
    nzcv_q = fl;
    if (ok && iw[4:0] < NREGS) gpr[iw[4:0]] = res;
    o.wen = ok && iw[4:0] < NREGS;
    o.rd = iw[4:0];
    o.val = res;
    o.nzcv = fl;
    o.bad = !ok;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    exec_result_t got, want;
    if (rst) begin
      for (int i = 0; i < NREGS; i++) gpr[i] = 64'd0;
      nzcv_q = 4'd0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(execute(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[74:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", got.val, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.wen !== want.wen) report_mismatch("write_enable", got.wen, want.wen);
          if (got.rd !== want.rd) report_mismatch("dest_index", got.rd, want.rd);
          if (got.val !== want.val) report_mismatch("write_value", got.val, want.val);
          if (got.nzcv !== want.nzcv) report_mismatch("flags_nzcv", got.nzcv, want.nzcv);
          if (got.bad !== want.bad) report_mismatch("invalid", got.bad, want.bad);
          if (m_axis_tdata[79:75] !== 5'd0) report_mismatch("pad", m_axis_tdata[79:75], 0);
        end
      end
    end
  end

endmodule

@@ dv/a64_data_processing_execute_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64_data_processing_execute_tb: stimulus and verdict
// Drives directed and random A64 data-processing instructions under three
// idle mixes and lets the checker predict and compare every result beat.
// ----------------------------------------------------------------------------
module a64_data_processing_execute_tb;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  int          errors, pending;
  int          send_idle_pct, recv_idle_pct;
  int          stall_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  a64_data_processing_execute DUT (.*);
  a64_data_processing_execute_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // hold the beat until accepted, with random idle cycles in front
  task automatic send_instr(logic act, logic [31:0] iw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= iw;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [31:0] random_instr(output logic act);
    logic [31:0] iw;
    int pick;
    iw = $urandom;
    pick = $urandom_range(99);
    act = pick >= 40;
    if ($urandom_range(3) == 0) iw[4:0] = $urandom_range(7);
    if ($urandom_range(3) == 0) iw[9:5] = $urandom_range(7);
    if ($urandom_range(3) == 0) iw[20:16] = $urandom_range(7);
    if (pick < 90) begin
      if (!act) begin
        iw[25:23] = $urandom_range(1) ? 3'b010 : 3'b101;
      end else if (pick < 80) begin
        iw[28] = 1'b0;
        if (iw[24]) iw[21] = ($urandom_range(9) == 0);
        if (!iw[31] && $urandom_range(9) != 0) iw[15] = 1'b0;
      end else begin
        iw[28] = 1'b1;
        iw[24:21] = 4'b1000;
      end
    end
    return iw;
  endfunction

  // let the checker see the last accepted beat before testing the count
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic act;
    logic [31:0] iw;
    send_idle_pct = 10;
    recv_idle_pct = 54;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wide moves, immediates at the extremes, flags, invalid groups
    send_instr(1'b0, 32'hd2bf_ffe1);   // MOVZ x1, #0xffff, lsl 16
    send_instr(1'b0, 32'hf29f_ffe1);   // MOVK x1 low half
    send_instr(1'b0, 32'h9280_0002);   // MOVN x2, #0
    send_instr(1'b0, 32'h52ff_ffe3);   // MOVZ 32-bit hw=3: invalid
    send_instr(1'b0, 32'hb2a0_0004);   // opc 01 wide move: invalid
    send_instr(1'b0, 32'hb100_0421);   // ADDS x1, x1, #1
    send_instr(1'b0, 32'hf17f_fc5f);   // SUBS xzr, x2, #0xfff, lsl 12
    send_instr(1'b0, 32'h3100_07e5);   // ADDS w5, wzr, #1
    send_instr(1'b0, 32'h7100_08a6);   // SUBS w6, w5, #2
    send_instr(1'b0, 32'h0300_0000);   // unknown immediate group
    send_instr(1'b1, 32'hab02_0027);   // ADDS x7, x1, x2
    send_instr(1'b1, 32'hcb82_fc28);   // SUB x8, x1, x2, asr 63
    send_instr(1'b1, 32'h0b42_7c29);   // ADD w9, w1, w2, lsr 31
    send_instr(1'b1, 32'h0b02_8029);   // 32-bit shift of 32: invalid
    send_instr(1'b1, 32'hab22_0020);   // arith with bit 21 set: invalid
    send_instr(1'b1, 32'h8ac2_002a);   // AND x10, x1, x2, ror 0
    send_instr(1'b1, 32'h8ac2_fc2b);   // AND ror 63
    send_instr(1'b1, 32'hea22_002c);   // BICS x12, x1, x2
    send_instr(1'b1, 32'hca62_042d);   // EON x13, x1, x2, lsr 1
    send_instr(1'b1, 32'haa3f_03ee);   // ORN x14, xzr, xzr
    send_instr(1'b1, 32'h9b02_0c2f);   // MADD x15, x1, x2, x3
    send_instr(1'b1, 32'h1b02_8c30);   // MSUB w16, w1, w2, w3
    send_instr(1'b1, 32'h9b42_0c31);   // multiply bad opcode: invalid
    send_instr(1'b1, 32'h6a1f_03e0);   // ANDS w0, wzr, wzr
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 54;
        recv_idle_pct = 10;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        iw = random_instr(act);
        send_instr(act, iw);
        if (i == 100) drain();
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/a64dp_pkg.sv
rtl/a64dp_decode.sv
rtl/a64dp_fifo.sv
rtl/a64dp_execute.sv
rtl/a64_data_processing_execute.sv
dv/a64_data_processing_execute_checker.sv
dv/a64_data_processing_execute_tb.sv
